/* hdl/mps_pkg.sv */
// Shared types, constants and codes of the mate pair selector.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mps_pkg;

	localparam int MAX_ALIGN  = 8;
	localparam int IDX_W      = (MAX_ALIGN > 1) ? $clog2(MAX_ALIGN) : 1;
	localparam int CNT_W      = $clog2(MAX_ALIGN + 1);
	localparam int SCORE_W    = 48;
	localparam int POS_W      = 33;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FIFO_DEPTH = 2;
	localparam int QUAL_W     = 17;
	localparam int DIV_W      = 64;

	localparam logic [CFG_IDX_W-1:0] REG_GENOME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEV    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BONUS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH  = 3'd4;

	localparam logic [1:0] ST_PAIR  = 2'd0;
	localparam logic [1:0] ST_PASS2 = 2'd1;
	localparam logic [1:0] ST_PASS1 = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	localparam logic [QUAL_W-1:0] Q_ONE = 17'd65536;

	typedef struct packed {
		logic [31:0] genome_length;
		logic [19:0] insert_mean;
		logic [19:0] insert_deviation;
		logic [15:0] pair_bonus;
		logic [7:0]  match_score;
	} cfg_t;

	typedef struct packed {
		logic              mate;
		logic signed [31:0] score;
		logic [POS_W-1:0]  pos;
		logic              rev;
		logic              usable;
		logic              few_seeds;
		logic [15:0]       qlen;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [2:0]                first_index;
		logic [2:0]                second_index;
		logic                      is_paired;
		logic signed [SCORE_W-1:0] best_score;
		logic [QUAL_W-1:0]         mapping_quality;
		logic                      quality_valid;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUAL_W-1:0] q;
	} div_rsp_t;

endpackage

/* hdl/mps_front.sv */
// Front end: classifies an incoming alignment beat into a queue entry.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_front (
	input  mps_pkg::cfg_t   cfg,
	input  logic            mate,
	input  logic [31:0]     align_score,
	input  logic [32:0]     ref_start,
	input  logic [15:0]     align_length,
	input  logic [15:0]     seed_count,
	input  logic [15:0]     query_length,
	input  logic            last,
	output mps_pkg::entry_t entry
);
	import mps_pkg::*;

	always_comb begin
		entry           = '0;
		entry.mate      = mate;
		entry.score     = $signed(align_score);
		entry.pos       = ref_start;
		// reverse strand starts at genome_length
		entry.rev       = ref_start >= {1'b0, cfg.genome_length};
		entry.usable    = align_length != 16'd0;
		entry.few_seeds = seed_count <= 16'd1;
		entry.qlen      = query_length;
		entry.last      = last;
	end

endmodule

/* hdl/mps_fifo.sv */
// Short queue of classified entries between front and back end.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  mps_pkg::entry_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output mps_pkg::entry_t rd_data
);
	import mps_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wptr_q, rptr_q;
	logic [FCNT_W-1:0]  cnt_q;
	logic               push, pop;

	assign wr_ready = cnt_q != FCNT_W'(FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

/* hdl/mps_div.sv */
// Restoring divider for the mapping quality, one quotient bit per cycle.
// Saturates at one in Q1.16. Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mps_pkg::div_req_t req,
	output mps_pkg::div_rsp_t rsp
);
	import mps_pkg::*;

	localparam int STEP_W = $clog2(QUAL_W);

	logic              busy_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  r_q, d_q;
	logic [QUAL_W-1:0] q_q;
	logic              ge;

	assign ge       = r_q >= d_q;
	assign rsp.done = done_q;
	assign rsp.q    = (q_q > Q_ONE) ? Q_ONE : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// quotient beyond 17 bits saturates right away
				if (req.num >= (req.den << QUAL_W)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(QUAL_W - 1);
				end
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.num;
			d_q <= req.den << (QUAL_W - 1);
			q_q <= (req.num >= (req.den << QUAL_W)) ? Q_ONE : '0;
		end else if (busy_q) begin
			if (ge) begin
				r_q <= r_q - d_q;
			end
			q_q <= {q_q[QUAL_W-2:0], ge};
			d_q <= d_q >> 1;
		end
	end

endmodule

/* hdl/mps_back.sv */
// Back end: alignment lists, pair search sequencer and result register.
// Depends on mps_pkg and mps_div.
`timescale 1ns / 1ps

module mps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mps_pkg::cfg_t    cfg,
	input  logic             q_valid,
	output logic             q_ready,
	input  mps_pkg::entry_t  q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output mps_pkg::result_t result
);
	import mps_pkg::*;

	typedef enum logic [7:0] {
		S_LOAD  = 8'b0000_0001,
		S_START = 8'b0000_0010,
		S_PA    = 8'b0000_0100,
		S_PB    = 8'b0000_1000,
		S_PC    = 8'b0001_0000,
		S_FIN   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// lists
	logic signed [31:0] f_score [MAX_ALIGN];
	logic signed [31:0] s_score [MAX_ALIGN];
	logic [POS_W-1:0]   f_pos   [MAX_ALIGN];
	logic [POS_W-1:0]   s_pos   [MAX_ALIGN];
	logic [MAX_ALIGN-1:0] f_rev, s_rev, f_use, s_use, f_few, s_few;
	logic [CNT_W-1:0]   n1_q, n2_q;
	logic [15:0]        rlen0_q, rlen1_q;

	logic [CNT_W-1:0]   i_q, j_q;
	logic [1:0]         np_q;
	logic [IDX_W-1:0]   fi, fj;

	// pair pipeline
	logic signed [32:0] sum_s1;
	logic signed [35:0] diff_s1;
	logic               mis_s1, few1_s1, few2_s1;
	logic signed [31:0] raw1_s1, raw2_s1;
	logic signed [49:0] prod_s2;
	logic               paired_s2;

	// running best
	logic signed [SCORE_W-1:0] best_q, second_q;
	logic                      have2_q, bp_q, bfew1_q, bfew2_q;
	logic [IDX_W-1:0]          bi_q, bj_q;
	logic signed [31:0]        braw1_q, braw2_q;
	result_t                   res_q;
	result_t                   res_nx;

	logic                      pop, st1, st2, pa_take, take, go_out, fin_div;
	logic signed [34:0]        p2m;
	logic signed [35:0]        diff, absd, lo, hi;
	logic [21:0]               dev3;
	logic signed [49:0]        prod, scaled;
	logic signed [SCORE_W-1:0] s_fin;
	logic signed [34:0]        s5a, s5b;
	logic [23:0]               mr0, mr1;
	logic                      fl1, fl2;
	logic [1:0]                ushift, hshift;
	logic [SCORE_W-1:0]        gap;
	div_req_t                  dreq;
	div_rsp_t                  drsp;

	assign fi        = i_q[IDX_W-1:0];
	assign fj        = j_q[IDX_W-1:0];
	assign q_ready   = state_q == S_LOAD;
	assign out_valid = state_q == S_OUT;
	assign result    = res_q;

	assign pop = (state_q == S_LOAD) && q_valid;
	assign st1 = pop && !q_data.mate && (n1_q < CNT_W'(MAX_ALIGN));
	assign st2 = pop && q_data.mate && (n2_q < CNT_W'(MAX_ALIGN));
	assign pa_take = (state_q == S_PA) && (i_q < n1_q) && f_use[fi] && (j_q < n2_q)
		&& s_use[fj];

	// second mate start mirrored onto the forward strand
	assign p2m  = $signed({2'b00, cfg.genome_length, 1'b0}) - $signed({2'b00, s_pos[fj]})
		- 35'sd1;
	assign diff = $signed({3'b000, f_pos[fi]}) - $signed({p2m[34], p2m});

	assign absd = (diff_s1 < 0) ? -diff_s1 : diff_s1;
	assign dev3 = {2'b00, cfg.insert_deviation} + {1'b0, cfg.insert_deviation, 1'b0};
	assign lo   = $signed({16'b0, cfg.insert_mean}) - $signed({14'b0, dev3});
	assign hi   = $signed({16'b0, cfg.insert_mean}) + $signed({14'b0, dev3});
	assign prod = sum_s1 * $signed({1'b0, cfg.pair_bonus});

	// truncate toward zero
	assign scaled = (prod_s2 < 0) ? ((prod_s2 + 50'sd255) >>> 8) : (prod_s2 >>> 8);
	assign s_fin  = paired_s2 ? scaled[SCORE_W-1:0]
		: {{(SCORE_W - 33){sum_s1[32]}}, sum_s1};
	assign take   = (np_q == 2'd0) || (s_fin > best_q) || ((s_fin == best_q) && paired_s2
		&& !bp_q);

	// full-length test per chosen mate
	assign s5a = $signed({{3{braw1_q[31]}}, braw1_q}) * 35'sd5;
	assign s5b = $signed({{3{braw2_q[31]}}, braw2_q}) * 35'sd5;
	assign mr0 = 24'(cfg.match_score) * 24'(rlen0_q);
	assign mr1 = 24'(cfg.match_score) * 24'(rlen1_q);
	assign fl1 = (s5a >= $signed({9'b0, mr0, 2'b00})) && (32'(n1_q) >= 3);
	assign fl2 = (s5b >= $signed({9'b0, mr1, 2'b00})) && (32'(n2_q) >= 3);
	assign ushift = {1'b0, fl1} + {1'b0, fl2};
	assign hshift = {1'b0, bfew1_q} + {1'b0, bfew2_q};
	assign gap    = best_q - second_q;

	assign fin_div = (state_q == S_FIN) && (np_q == 2'd2) && bp_q && (best_q > 0);
	assign go_out  = ((state_q == S_START) && ((n1_q == '0) || (n2_q == '0)))
		|| ((state_q == S_FIN) && !fin_div)
		|| ((state_q == S_DIV) && drsp.done);

	always_comb begin
		dreq       = '0;
		dreq.start = fin_div;
		dreq.num   = {16'b0, gap} << (16 + ushift);
		dreq.den   = {16'b0, best_q} << hshift;
	end

	// result word formed at the start of a search and again at its end
	always_comb begin
		res_nx = '0;
		if (state_q == S_START) begin
			res_nx.status = (n1_q == '0) ? ST_PASS2 : ST_PASS1;
		end else if (np_q == 2'd0) begin
			res_nx.status = ST_NONE;
		end else begin
			res_nx.status        = ST_PAIR;
			res_nx.first_index   = 3'(bi_q);
			res_nx.second_index  = 3'(bj_q);
			res_nx.is_paired     = bp_q;
			res_nx.best_score    = best_q;
			res_nx.quality_valid = bp_q && (np_q == 2'd2);
		end
	end

	mps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			n1_q    <= '0;
			n2_q    <= '0;
			rlen0_q <= '0;
			rlen1_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			np_q    <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (pop) begin
						if (q_data.mate) begin
							rlen1_q <= q_data.qlen;
						end else begin
							rlen0_q <= q_data.qlen;
						end
						if (st1) begin
							n1_q <= n1_q + 1'b1;
						end
						if (st2) begin
							n2_q <= n2_q + 1'b1;
						end
						if (q_data.last) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					i_q  <= '0;
					j_q  <= '0;
					np_q <= '0;
					// empty the lists once the result is formed
					if (go_out) begin
						state_q <= S_OUT;
						n1_q    <= '0;
						n2_q    <= '0;
					end else begin
						state_q <= S_PA;
					end
				end
				S_PA: begin
					if (i_q >= n1_q) begin
						state_q <= S_FIN;
					end else if (!f_use[fi] || (j_q >= n2_q)) begin
						i_q <= i_q + 1'b1;
						j_q <= '0;
					end else if (!s_use[fj]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_PB;
					end
				end
				S_PB: state_q <= S_PC;
				S_PC: begin
					if (np_q != 2'd2) begin
						np_q <= np_q + 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_PA;
				end
				S_FIN: begin
					if (go_out) begin
						state_q <= S_OUT;
						n1_q    <= '0;
						n2_q    <= '0;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (go_out) begin
						state_q <= S_OUT;
						n1_q    <= '0;
						n2_q    <= '0;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st1) begin
			f_score[n1_q[IDX_W-1:0]] <= q_data.score;
			f_pos[n1_q[IDX_W-1:0]]   <= q_data.pos;
			f_rev[n1_q[IDX_W-1:0]]   <= q_data.rev;
			f_use[n1_q[IDX_W-1:0]]   <= q_data.usable;
			f_few[n1_q[IDX_W-1:0]]   <= q_data.few_seeds;
		end
		if (st2) begin
			s_score[n2_q[IDX_W-1:0]] <= q_data.score;
			s_pos[n2_q[IDX_W-1:0]]   <= q_data.pos;
			s_rev[n2_q[IDX_W-1:0]]   <= q_data.rev;
			s_use[n2_q[IDX_W-1:0]]   <= q_data.usable;
			s_few[n2_q[IDX_W-1:0]]   <= q_data.few_seeds;
		end
		if (pa_take) begin
			sum_s1  <= {f_score[fi][31], f_score[fi]} + {s_score[fj][31], s_score[fj]};
			diff_s1 <= diff;
			mis_s1  <= f_rev[fi] != s_rev[fj];
			raw1_s1 <= f_score[fi];
			raw2_s1 <= s_score[fj];
			few1_s1 <= f_few[fi];
			few2_s1 <= s_few[fj];
		end
		if (state_q == S_PB) begin
			paired_s2 <= mis_s1 && (absd >= lo) && (absd <= hi);
			prod_s2   <= prod;
		end
		if (state_q == S_START) begin
			have2_q <= 1'b0;
			bp_q    <= 1'b0;
			best_q  <= '0;
		end
		if (state_q == S_PC) begin
			if (take) begin
				// dethroned best joins the runner-up race
				if (np_q != 2'd0 && (!have2_q || best_q > second_q)) begin
					second_q <= best_q;
					have2_q  <= 1'b1;
				end
				best_q  <= s_fin;
				bp_q    <= paired_s2;
				bi_q    <= fi;
				bj_q    <= fj;
				braw1_q <= raw1_s1;
				braw2_q <= raw2_s1;
				bfew1_q <= few1_s1;
				bfew2_q <= few2_s1;
			end else if (!have2_q || s_fin > second_q) begin
				second_q <= s_fin;
				have2_q  <= 1'b1;
			end
		end
		if (state_q == S_START || state_q == S_FIN) begin
			res_q <= res_nx;
		end else if (state_q == S_DIV && drsp.done) begin
			res_q.mapping_quality <= drsp.q;
		end
	end

endmodule

/* hdl/mate_pair_selector.sv */
// Mate pair selector: loads alignments at one beat per cycle while the back end is loading,
// and picks the best mate pair. Throughput: one alignment per cycle while loading; the back
// end sequencer visits the pairs one at a time through states S_PA, S_PB and S_PC. Reset
// restores the register defaults, empties the lists and the queue.
// Depends on mps_pkg, mps_front, mps_fifo, mps_back.
`timescale 1ns / 1ps

module mate_pair_selector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mps_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mate,
	input  logic [31:0]                         align_score,
	input  logic [32:0]                         ref_start,
	input  logic [15:0]                         align_length,
	input  logic [15:0]                         seed_count,
	input  logic [15:0]                         query_length,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [2:0]                          first_index,
	output logic [2:0]                          second_index,
	output logic                                is_paired,
	output logic signed [mps_pkg::SCORE_W-1:0]  best_score,
	output logic [mps_pkg::QUAL_W-1:0]          mapping_quality,
	output logic                                quality_valid
);
	import mps_pkg::*;

	cfg_t    cfg_q;
	entry_t  entry, q_data;
	logic    q_valid, q_ready;
	result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.genome_length    <= 32'd1;
			cfg_q.insert_mean      <= 20'd300;
			cfg_q.insert_deviation <= 20'd50;
			cfg_q.pair_bonus       <= 16'd256;
			cfg_q.match_score      <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GENOME: cfg_q.genome_length    <= cfg_data;
				REG_MEAN:   cfg_q.insert_mean      <= cfg_data[19:0];
				REG_DEV:    cfg_q.insert_deviation <= cfg_data[19:0];
				REG_BONUS:  cfg_q.pair_bonus       <= cfg_data[15:0];
				REG_MATCH:  cfg_q.match_score      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mps_front u_front (
		.cfg          (cfg_q),
		.mate         (mate),
		.align_score  (align_score),
		.ref_start    (ref_start),
		.align_length (align_length),
		.seed_count   (seed_count),
		.query_length (query_length),
		.last         (last),
		.entry        (entry)
	);

	mps_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_ready (in_ready),
		.wr_data  (entry),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	mps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign status          = result.status;
	assign first_index     = result.first_index;
	assign second_index    = result.second_index;
	assign is_paired       = result.is_paired;
	assign best_score      = result.best_score;
	assign mapping_quality = result.mapping_quality;
	assign quality_valid   = result.quality_valid;

endmodule

/* hdl/mps_checker.sv */
// Port-level checks of the mate pair selector, bound to the top level.
// Depends on mps_pkg and mate_pair_selector.
`timescale 1ns / 1ps

module mps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [1:0]                          status,
	input logic [2:0]                          first_index,
	input logic [2:0]                          second_index,
	input logic                                is_paired,
	input logic signed [mps_pkg::SCORE_W-1:0]  best_score,
	input logic [mps_pkg::QUAL_W-1:0]          mapping_quality,
	input logic                                quality_valid
);
	import mps_pkg::*;

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(best_score)
		&& $stable(mapping_quality))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_PAIR) |-> (first_index == 3'd0) && (second_index == 3'd0)
		&& !is_paired && (best_score == '0) && !quality_valid)
		else $error("non-pair result carries data");

	a_qpair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quality_valid |-> is_paired)
		else $error("quality on unpaired result");

	a_qmax: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mapping_quality <= Q_ONE)
		else $error("quality above one");

	a_qzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!quality_valid || best_score <= 0) |-> mapping_quality == '0)
		else $error("quality without computation");

endmodule

bind mate_pair_selector mps_checker u_mps_checker (.*);

/* dv/mate_pair_selector_tb.sv */
// Self-checking testbench for mate_pair_selector: random read pairs under several settings.
// It predicts each result in a scoreboard class and checks the outputs against it.
// Depends on mps_pkg and the mate_pair_selector RTL.
`timescale 1ns / 1ps

module mate_pair_selector_tb;
	import mps_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int ITEM_TARGET    = 1750;

	typedef struct {
		bit         mate;
		bit [31:0]  score;
		bit [32:0]  pos;
		bit [15:0]  len;
		bit [15:0]  seeds;
		bit [15:0]  qlen;
		bit         last;
	} alignment_t;

	class pair_scoreboard;
		longint genome, mean, dev, bonus, match;
		longint scores [2][MAX_ALIGN];
		longint posns  [2][MAX_ALIGN];
		bit     usable [2][MAX_ALIGN];
		int     seeds  [2][MAX_ALIGN];
		int     counts [2];
		longint rlen   [2];
		result_t pending_results [$];
		int     mismatches;

		function new();
			genome = 1; mean = 300; dev = 50; bonus = 256; match = 2;
			counts = '{0, 0};
			rlen = '{0, 0};
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
			case (idx)
				REG_GENOME: genome = val;
				REG_MEAN:   mean = val[19:0];
				REG_DEV:    dev = val[19:0];
				REG_BONUS:  bonus = val[15:0];
				REG_MATCH:  match = val[7:0];
				default: ;
			endcase
		endfunction

		function longint combined_score(int i, int j, output bit paired);
			longint s, p1, p2, d, lo, hi;
			bit r1, r2;
			s = scores[0][i] + scores[1][j];
			r1 = posns[0][i] >= genome;
			r2 = posns[1][j] >= genome;
			paired = 0;
			if (r1 != r2) begin
				p1 = posns[0][i];
				p2 = 2 * genome - posns[1][j] - 1;
				d = (p1 > p2) ? p1 - p2 : p2 - p1;
				lo = mean - 3 * dev;
				hi = mean + 3 * dev;
				if (d >= lo && d <= hi) begin
					s = (s * bonus) / 256;
					paired = 1;
				end
			end
			return s;
		endfunction

		function bit near_full_length(longint s, int m);
			return (s * 5 >= match * rlen[m] * 4) && counts[m] >= 3;
		endfunction

		function result_t pick_pair();
			result_t r;
			int bi, bj, npairs;
			longint best, runner_up, s;
			bit bp, p, have2;
			bit [63:0] num, den, q;
			r = '0;
			bi = 0; bj = 0; npairs = 0; best = 0; runner_up = 0; bp = 0; have2 = 0;
			if (counts[0] == 0) begin
				r.status = ST_PASS2;
				return r;
			end
			if (counts[1] == 0) begin
				r.status = ST_PASS1;
				return r;
			end
			for (int i = 0; i < counts[0]; i++) begin
				if (!usable[0][i]) continue;
				for (int j = 0; j < counts[1]; j++) begin
					if (!usable[1][j]) continue;
					s = combined_score(i, j, p);
					if (npairs == 0 || s > best || (s == best && p && !bp)) begin
						best = s; bp = p; bi = i; bj = j;
					end
					npairs++;
				end
			end
			if (npairs == 0) begin
				r.status = ST_NONE;
				return r;
			end
			r.status = ST_PAIR;
			r.first_index = bi[2:0];
			r.second_index = bj[2:0];
			r.is_paired = bp;
			r.best_score = best[47:0];
			if (!bp || npairs < 2) return r;
			for (int i = 0; i < counts[0]; i++) begin
				if (!usable[0][i]) continue;
				for (int j = 0; j < counts[1]; j++) begin
					if (!usable[1][j] || (i == bi && j == bj)) continue;
					s = combined_score(i, j, p);
					if (!have2 || s > runner_up) begin
						runner_up = s;
						have2 = 1;
					end
				end
			end
			r.quality_valid = 1;
			if (best <= 0) return r;
			num = 64'(best - runner_up) << 16;
			den = 64'(best);
			if (seeds[0][bi] <= 1) den = den << 1;
			if (seeds[1][bj] <= 1) den = den << 1;
			if (near_full_length(scores[0][bi], 0)) num = num << 1;
			if (near_full_length(scores[1][bj], 1)) num = num << 1;
			q = num / den;
			r.mapping_quality = (q > 65536) ? Q_ONE : q[16:0];
			return r;
		endfunction

		function void note_alignment(alignment_t a);
			int c;
			c = counts[a.mate];
			rlen[a.mate] = a.qlen;
			if (c < MAX_ALIGN) begin
				scores[a.mate][c] = longint'(signed'(a.score));
				posns[a.mate][c] = a.pos;
				usable[a.mate][c] = a.len != 0;
				seeds[a.mate][c] = a.seeds;
				counts[a.mate] = c + 1;
			end
			if (a.last) begin
				pending_results.insert(pending_results.size(), pick_pair());
				counts = '{0, 0};
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			exp = pending_results.pop_front();
			if (got.status !== exp.status || got.first_index !== exp.first_index
					|| got.second_index !== exp.second_index || got.is_paired !== exp.is_paired
					|| got.best_score !== exp.best_score
					|| got.mapping_quality !== exp.mapping_quality
					|| got.quality_valid !== exp.quality_valid) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
			end
		endfunction
	endclass

	logic                   clk, arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid, in_ready;
	logic                   mate, last;
	logic [31:0]            align_score;
	logic [32:0]            ref_start;
	logic [15:0]            align_length, seed_count, query_length;
	logic                   out_valid, out_ready;
	logic [1:0]             status;
	logic [2:0]             first_index, second_index;
	logic                   is_paired, quality_valid;
	logic signed [SCORE_W-1:0] best_score;
	logic [QUAL_W-1:0]      mapping_quality;

	pair_scoreboard sb = new();
	bit  quiet, hold_req;
	int  items_sent, stall_cycles;

	mate_pair_selector DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver side
	initial begin
		out_ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (300) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (out_valid && out_ready) begin
			got.status = status;
			got.first_index = first_index;
			got.second_index = second_index;
			got.is_paired = is_paired;
			got.best_score = best_score;
			got.mapping_quality = mapping_quality;
			got.quality_valid = quality_valid;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("mate_pair_selector verification failed");
			$finish;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic send(alignment_t a);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1;
		mate <= a.mate;
		align_score <= a.score;
		ref_start <= a.pos;
		align_length <= a.len;
		seed_count <= a.seeds;
		query_length <= a.qlen;
		last <= a.last;
		do @(posedge clk); while (!in_ready);
		sb.note_alignment(a);
		items_sent++;
	endtask

	task automatic send_fields(bit m, bit [31:0] s, bit [32:0] p, bit [15:0] l, bit [15:0] sd,
			bit [15:0] q, bit lst);
		alignment_t a;
		a.mate = m; a.score = s; a.pos = p; a.len = l; a.seeds = sd; a.qlen = q; a.last = lst;
		send(a);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one read pair: forward anchor, mate positions mostly around the insert window
	task automatic send_read_pair(int n1, int n2);
		alignment_t a;
		bit         mates [$];
		longint     anchor, mapped, off, thr;
		for (int k = 0; k < n1; k++) mates.insert(mates.size(), 1'b0);
		for (int k = 0; k < n2; k++) mates.insert(mates.size(), 1'b1);
		mates.shuffle();
		anchor = (sb.genome > 1) ? $urandom_range(0, 32'(sb.genome - 1)) : 0;
		foreach (mates[k]) begin
			a.mate = mates[k];
			a.qlen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(50, 300));
			thr = (sb.match * a.qlen * 4) / 5;
			case ($urandom_range(0, 3))
				0: a.score = $urandom;
				1: a.score = 32'(thr + $urandom_range(0, 2) - 1);
				default: a.score = 32'($urandom_range(0, 400) - 100);
			endcase
			off = longint'($urandom_range(0, 6 * 32'(sb.dev) + 10)) - (3 * sb.dev + 5);
			if ($urandom_range(0, 7) == 0)
				a.pos = {1'($urandom), 32'($urandom)};
			else if (a.mate == 0)
				a.pos = 33'(anchor + $urandom_range(0, 3));
			else begin
				mapped = anchor + sb.mean + off;
				a.pos = 33'(2 * sb.genome - 1 - mapped);
			end
			a.len = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
			a.seeds = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
			a.last = (k == mates.size() - 1);
			send(a);
		end
	endtask

	task automatic random_config(int phase);
		case (phase % 5)
			1: begin
				cfg_write(REG_GENOME, 1);
				cfg_write(REG_MEAN, 0);
				cfg_write(REG_DEV, 0);
				cfg_write(REG_BONUS, 0);
				cfg_write(REG_MATCH, 0);
			end
			2: begin
				cfg_write(REG_GENOME, 32'hFFFF_FFFF);
				cfg_write(REG_MEAN, 20'hFFFFF);
				cfg_write(REG_DEV, 20'hFFFFF);
				cfg_write(REG_BONUS, 16'hFFFF);
				cfg_write(REG_MATCH, 8'hFF);
			end
			default: begin
				cfg_write(REG_GENOME, $urandom_range(1000, 1000000));
				cfg_write(REG_MEAN, $urandom_range(100, 500));
				cfg_write(REG_DEV, $urandom_range(0, 100));
				cfg_write(REG_BONUS, $urandom_range(200, 600));
				cfg_write(REG_MATCH, $urandom_range(1, 4));
			end
		endcase
	endtask

	initial begin
		int phase;
		arst_n <= 0;
		cfg_we <= 0; cfg_index <= '0; cfg_data <= '0;
		in_valid <= 0; mate <= 0; align_score <= '0; ref_start <= '0;
		align_length <= '0; seed_count <= '0; query_length <= '0; last <= 0;
		quiet = 0; hold_req = 0; items_sent = 0; stall_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset defaults, forward strand is position 0 only
		send_fields(1, 10, 301, 5, 3, 100, 1);                    // first list empty
		send_fields(0, 10, 0, 5, 3, 100, 1);                      // second list empty
		send_fields(0, 7, 0, 0, 3, 100, 0);                       // no usable pair
		send_fields(1, 7, 301, 0, 3, 100, 1);
		send_fields(0, 100, 0, 80, 5, 100, 0);                    // higher unpaired beats paired
		send_fields(1, 100, 301, 80, 0, 100, 0);
		send_fields(1, 150, 5000, 80, 1, 100, 0);
		send_fields(1, 90, 200, 80, 7, 100, 1);
		send_fields(0, -32'sd10, 0, 9, 2, 20, 0);                 // negative paired best
		send_fields(1, -32'sd10, 301, 9, 2, 20, 0);
		send_fields(1, -32'sd400, 9000, 9, 2, 20, 1);
		send_fields(0, 50, 0, 9, 2, 20, 0);                       // tie on equal scores
		send_fields(1, 50, 9000, 9, 2, 20, 0);
		send_fields(1, 50, 301, 9, 2, 20, 1);
		for (int k = 0; k < 9; k++)                               // full first list
			send_fields(0, 32'(k * 3), 0, 16'(k + 1), 16'(k), 16'hFFFF, 0);
		send_fields(1, 32'h7FFF_FFFF, 33'h1_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 1);
		send_fields(0, 32'h8000_0000, 33'h1_FFFF_FFFF, 16'hFFFF, 0, 16'hFFFF, 0);
		send_fields(1, 32'h8000_0000, 0, 1, 16'hFFFF, 0, 1);
		drain();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase > 0) random_config(phase);
			if (items_sent > ITEM_TARGET - 300) quiet = 1;
			if (phase == 3) hold_req = 1;
			for (int r = 0; r < 12; r++) begin
				if ($urandom_range(0, 15) == 0)
					send_read_pair($urandom_range(0, 10), $urandom_range(0, 10));
				else
					send_read_pair($urandom_range(1, 4), $urandom_range(1, 4));
				if (phase == 4 && r == 5) begin
					in_valid <= 0;
					while (sb.pending_results.size() != 0) @(posedge clk);
				end
			end
			drain();
			phase++;
		end

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("mate_pair_selector verification clean");
		else
			$display("mate_pair_selector verification failed");
		$finish;
	end

endmodule
